// ===== hw/rtl/cdg_pkg.sv =====
`timescale 1ns / 1ps
// cdg_pkg: shared widths, register indexes and transaction types for the
// central difference gradient core. No dependencies.
package cdg_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int PIX_BITS    = 16;
    localparam int GRAD_BITS   = PIX_BITS + 1;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int WREG_BITS   = 11;
    localparam int HREG_BITS   = 13;
    localparam int CFG_DBITS   = 13;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;
    localparam int MAX_PUSH    = 3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [COL_BITS-1:0] RST_COL_LAST = COL_BITS'(640 - 1);
    localparam logic [ROW_BITS-1:0] RST_ROW_LAST = ROW_BITS'(480 - 1);

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic [ROW_BITS-1:0]         row;
        logic [COL_BITS-1:0]         col;
        logic                        frame_end;
    } t_result;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                above_en;
        logic                gy_en;
        logic                x_edge;
        logic                last_row;
        logic                col_ge1;
        logic                col_ge2;
        logic                col_last;
    } t_stage;

endpackage

// ===== hw/rtl/cdg_line_store.sv =====
`timescale 1ns / 1ps
// cdg_line_store: the two row memories (previous row, row before it) with
// read-first access and the delayed write-back into the older row. Uses cdg_pkg.
module cdg_line_store
    import cdg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [COL_BITS-1:0] i_col,
    input  logic [PIX_BITS-1:0] i_pixel,
    output logic [PIX_BITS-1:0] o_newer_cur,
    output logic [PIX_BITS-1:0] o_newer_next,
    output logic [PIX_BITS-1:0] o_older_cur
);

    logic [PIX_BITS-1:0] r_newer [MAX_WIDTH];
    logic [PIX_BITS-1:0] r_older [MAX_WIDTH];
    logic [PIX_BITS-1:0] r_newer_cur;
    logic [PIX_BITS-1:0] r_newer_next;
    logic [PIX_BITS-1:0] r_older_cur;
    logic [COL_BITS-1:0] r_wb_col;
    logic                r_wb_en;
    logic [COL_BITS-1:0] w_col_next;

    assign w_col_next = i_col + COL_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_newer_cur    <= r_newer[i_col];
            r_newer_next   <= r_newer[w_col_next];
            r_newer[i_col] <= i_pixel;
            r_wb_col       <= i_col;
        end
    end

    // older row takes the old newer-row value in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_older_cur <= r_older[i_col];
        end
        if (r_wb_en) begin
            r_older[r_wb_col] <= r_newer_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_en <= 1'b0;
        end else begin
            r_wb_en <= i_rd_en;
        end
    end

    assign o_newer_cur  = r_newer_cur;
    assign o_newer_next = r_newer_next;
    assign o_older_cur  = r_older_cur;

endmodule

// ===== hw/rtl/cdg_grad_calc.sv =====
`timescale 1ns / 1ps
// cdg_grad_calc: forms the up to three results of one pixel from the stage
// register and the row memory data; holds the last-row pixel history. Uses cdg_pkg.
module cdg_grad_calc
    import cdg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic                i_valid,
    input  t_stage              i_stage,
    input  logic [PIX_BITS-1:0] i_newer_cur,
    input  logic [PIX_BITS-1:0] i_newer_next,
    input  logic [PIX_BITS-1:0] i_older_cur,
    output logic [1:0]          o_push_n,
    output t_result [MAX_PUSH-1:0] o_res
);

    logic [PIX_BITS-1:0] r_left;
    logic [PIX_BITS-1:0] r_prev;
    logic [PIX_BITS-1:0] r_prev2;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_left <= i_newer_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_prev  <= '0;
            r_prev2 <= '0;
        end else if (i_valid && i_stage.last_row) begin
            r_prev2 <= r_prev;
            r_prev  <= i_stage.pixel;
        end
    end

    always_comb begin
        o_res[0].grad_x    = i_stage.x_edge ? '0 :
                             $signed({1'b0, i_newer_next}) - $signed({1'b0, r_left});
        o_res[0].grad_y    = i_stage.gy_en ?
                             $signed({1'b0, i_stage.pixel}) - $signed({1'b0, i_older_cur}) :
                             '0;
        o_res[0].row       = i_stage.row - ROW_BITS'(1);
        o_res[0].col       = i_stage.col;
        o_res[0].frame_end = 1'b0;

        o_res[1].grad_x    = i_stage.col_ge2 ?
                             $signed({1'b0, i_stage.pixel}) - $signed({1'b0, r_prev2}) :
                             '0;
        o_res[1].grad_y    = '0;
        o_res[1].row       = i_stage.row;
        o_res[1].col       = i_stage.col - COL_BITS'(1);
        o_res[1].frame_end = 1'b0;

        o_res[2].grad_x    = '0;
        o_res[2].grad_y    = '0;
        o_res[2].row       = i_stage.row;
        o_res[2].col       = i_stage.col;
        o_res[2].frame_end = 1'b1;

        // last row implies row >= 2 and the final column implies col >= 2,
        // so the valid results always form a prefix
        if (!i_valid || !i_stage.above_en) begin
            o_push_n = 2'd0;
        end else if (!i_stage.last_row || !i_stage.col_ge1) begin
            o_push_n = 2'd1;
        end else if (!i_stage.col_last) begin
            o_push_n = 2'd2;
        end else begin
            o_push_n = 2'd3;
        end
    end

endmodule

// ===== hw/rtl/cdg_out_queue.sv =====
`timescale 1ns / 1ps
// cdg_out_queue: small result queue taking up to three transactions per cycle
// and delivering one per cycle while i_pop is high. Uses cdg_pkg.
module cdg_out_queue
    import cdg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_n,
    input  t_result [MAX_PUSH-1:0] i_push_data,
    input  logic                   i_pop,
    output logic [QUEUE_CW-1:0]    o_count,
    output t_result                o_head
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_head;
    logic [QUEUE_AW-1:0] r_tail;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_AW-1:0] w_idx [MAX_PUSH];
    logic                w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            w_idx[k] = r_tail + QUEUE_AW'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < i_push_n) begin
                r_mem[w_idx[k]] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + QUEUE_AW'(i_push_n);
            r_head  <= r_head + QUEUE_AW'(w_pop);
            r_count <= r_count + QUEUE_CW'(i_push_n) - QUEUE_CW'(w_pop);
        end
    end

    assign o_count = r_count;
    assign o_head  = r_mem[r_head];

endmodule

// ===== hw/rtl/central_difference_gradient_core.sv =====
`timescale 1ns / 1ps
// central_difference_gradient_core: top level. Frame counters, configuration
// registers, stage register, row memories, result queue. Uses cdg_pkg and submodules.
//
// Usage:
//   Pixels enter in raster order on i_valid/i_pixel; a transaction completes
//   when i_valid is high and o_stall is low. Results leave on o_valid with
//   o_grad_x, o_grad_y, o_out_row, o_out_col, o_frame_end; the receiver holds
//   i_stall high to keep the current result in place.
//   Row 0 yields no result. Pixel (r,c) of a middle row yields the result for
//   (r-1,c). On the last row each pixel of column 1 or more also yields (r,c-1),
//   and the final pixel adds (r,W-1) with o_frame_end set.
//   A pixel passes the stage register and its results then enter the result queue.
//   Throughput: one pixel per cycle while o_stall is low, set by the single write
//   port of each row memory; on the last row the output drains one result per
//   cycle while i_stall is low, so o_stall holds input back there once the
//   8-entry queue has backed up.
//   o_stall rises when the queue cannot take the three results one pixel may add.
//   Width and height are written through i_cfg_valid/o_cfg_ready/i_cfg_index/
//   i_cfg_data while idle; a write restarts the frame position.
//   Reset (synchronous, active low) restores 640 x 480, empties the queue and
//   restarts the frame; row memory contents are kept, no clearing pass.
module central_difference_gradient_core
    import cdg_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [PIX_BITS-1:0]         i_pixel,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [GRAD_BITS-1:0] o_grad_x,
    output logic signed [GRAD_BITS-1:0] o_grad_y,
    output logic [ROW_BITS-1:0]         o_out_row,
    output logic [COL_BITS-1:0]         o_out_col,
    output logic                        o_frame_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [CFG_DBITS-1:0]        i_cfg_data
);

    logic [COL_BITS-1:0]    r_col_last;
    logic [ROW_BITS-1:0]    r_row_last;
    logic [COL_BITS-1:0]    r_col;
    logic [ROW_BITS-1:0]    r_row;
    logic [COL_BITS-1:0]    n_col;
    logic [ROW_BITS-1:0]    n_row;
    logic                   r_s1_valid;
    t_stage                 r_s1;
    t_stage                 n_s1;
    logic                   w_accept;
    logic                   w_cfg_we;
    logic [WREG_BITS-1:0]   w_wval;
    logic [HREG_BITS-1:0]   w_hval;
    logic [COL_BITS-1:0]    w_wlast;
    logic [ROW_BITS-1:0]    w_hlast;
    logic [PIX_BITS-1:0]    w_newer_cur;
    logic [PIX_BITS-1:0]    w_newer_next;
    logic [PIX_BITS-1:0]    w_older_cur;
    logic [1:0]             w_push_n;
    t_result [MAX_PUSH-1:0] w_res;
    logic [QUEUE_CW-1:0]    w_q_count;
    t_result                w_head;
    logic                   w_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_wval      = i_cfg_data[WREG_BITS-1:0];
    assign w_hval      = i_cfg_data[HREG_BITS-1:0];

    always_comb begin
        if (w_wval < WREG_BITS'(3)) begin
            w_wlast = COL_BITS'(2);
        end else if (w_wval > WREG_BITS'(MAX_WIDTH)) begin
            w_wlast = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_wlast = COL_BITS'(w_wval - WREG_BITS'(1));
        end
        if (w_hval < HREG_BITS'(3)) begin
            w_hlast = ROW_BITS'(2);
        end else if (w_hval > HREG_BITS'(MAX_HEIGHT)) begin
            w_hlast = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            w_hlast = ROW_BITS'(w_hval - HREG_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= RST_COL_LAST;
            r_row_last <= RST_ROW_LAST;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_col_last <= w_wlast;
                CFG_HEIGHT: r_row_last <= w_hlast;
                default:    r_col_last <= r_col_last;
            endcase
        end
    end

    // queue must take the worst case of one more pixel on top of what is in flight
    assign o_stall  = (QUEUE_CW'(1) + w_q_count + QUEUE_CW'(w_push_n) + QUEUE_CW'(MAX_PUSH))
                      > QUEUE_CW'(QUEUE_DEPTH + 1);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (r_col == r_col_last) begin
            n_col = '0;
            n_row = (r_row == r_row_last) ? '0 : r_row + ROW_BITS'(1);
        end else begin
            n_col = r_col + COL_BITS'(1);
            n_row = r_row;
        end
        n_s1.pixel    = i_pixel;
        n_s1.row      = r_row;
        n_s1.col      = r_col;
        n_s1.above_en = (r_row != '0);
        n_s1.gy_en    = (r_row > ROW_BITS'(1));
        n_s1.x_edge   = (r_col == '0) || (r_col == r_col_last);
        n_s1.last_row = (r_row == r_row_last);
        n_s1.col_ge1  = (r_col != '0);
        n_s1.col_ge2  = (r_col > COL_BITS'(1));
        n_s1.col_last = (r_col == r_col_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    cdg_line_store u_line_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (w_accept),
        .i_col        (r_col),
        .i_pixel      (i_pixel),
        .o_newer_cur  (w_newer_cur),
        .o_newer_next (w_newer_next),
        .o_older_cur  (w_older_cur)
    );

    cdg_grad_calc u_grad_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (w_cfg_we),
        .i_valid      (r_s1_valid),
        .i_stage      (r_s1),
        .i_newer_cur  (w_newer_cur),
        .i_newer_next (w_newer_next),
        .i_older_cur  (w_older_cur),
        .o_push_n     (w_push_n),
        .o_res        (w_res)
    );

    assign w_pop = o_valid && !i_stall;

    cdg_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (w_push_n),
        .i_push_data (w_res),
        .i_pop       (w_pop),
        .o_count     (w_q_count),
        .o_head      (w_head)
    );

    assign o_valid     = (w_q_count != '0);
    assign o_grad_x    = w_head.grad_x;
    assign o_grad_y    = w_head.grad_y;
    assign o_out_row   = w_head.row;
    assign o_out_col   = w_head.col;
    assign o_frame_end = w_head.frame_end;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_stage_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid && (r_s1.pixel == $past(i_pixel)))
        else $error("accepted pixel did not reach the stage register");

    a_frame_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> (o_out_row == r_row_last) && (o_out_col == r_col_last))
        else $error("frame end flag away from the final pixel");

    a_push_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n > 2'd1) |-> r_s1_valid && r_s1.last_row)
        else $error("extra results outside the last row");

endmodule

// ===== verif/central_difference_gradient_core_test.sv =====
`timescale 1ns / 1ps
// central_difference_gradient_core_test: self-checking bench for the gradient core.
// A scoreboard class predicts every result from the accepted pixels and checks each
// one in order, while random bursts and stalls load both sides. Uses cdg_pkg.
module central_difference_gradient_core_test;
    import cdg_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int ITEM_TARGET = 370;
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_HEAVY    = 2;

    class gradient_scoreboard;
        logic [WREG_BITS-1:0] width_reg;
        logic [HREG_BITS-1:0] height_reg;
        logic [PIX_BITS-1:0]  older_line [MAX_WIDTH];
        logic [PIX_BITS-1:0]  newer_line [MAX_WIDTH];
        int unsigned          row_idx;
        int unsigned          col_idx;
        logic [PIX_BITS-1:0]  tail_prev;
        logic [PIX_BITS-1:0]  tail_prev2;
        t_result              expected_q [$];
        int                   errors;
        int                   checked;
        int                   pixels;

        function new();
            foreach (older_line[i]) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            width_reg  = WREG_BITS'(640);
            height_reg = HREG_BITS'(480);
            errors     = 0;
            checked    = 0;
            pixels     = 0;
            restart();
        endfunction

        function void restart();
            row_idx    = 0;
            col_idx    = 0;
            tail_prev  = '0;
            tail_prev2 = '0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DBITS-1:0] data);
            if (idx == CFG_WIDTH) begin
                width_reg = data[WREG_BITS-1:0];
            end else begin
                height_reg = data[HREG_BITS-1:0];
            end
            restart();
        endfunction

        function logic signed [GRAD_BITS-1:0] slope(logic [PIX_BITS-1:0] a,
                                                     logic [PIX_BITS-1:0] b);
            return {1'b0, a} - {1'b0, b};
        endfunction

        function void note_pixel(logic [PIX_BITS-1:0] px);
            int unsigned         w;
            int unsigned         h;
            int unsigned         r;
            int unsigned         c;
            logic [PIX_BITS-1:0] above;
            t_result             res;
            pixels++;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            h = height_reg;
            if (h < 3) h = 3;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            r = row_idx;
            c = col_idx;
            if (c >= w) c = w - 1;
            if (r >= h) r = h - 1;

            above         = older_line[c];
            older_line[c] = newer_line[c];
            newer_line[c] = px;

            if (r >= 1) begin
                res     = '0;
                res.row = ROW_BITS'(r - 1);
                res.col = COL_BITS'(c);
                if (c != 0 && c != w - 1) res.grad_x = slope(newer_line[c + 1], older_line[c - 1]);
                if (r - 1 != 0) res.grad_y = slope(px, above);
                expected_q.push_back(res);
            end

            // last row runs one column behind and flushes on the final pixel
            if (r == h - 1) begin
                if (c >= 1) begin
                    res     = '0;
                    res.row = ROW_BITS'(r);
                    res.col = COL_BITS'(c - 1);
                    if (c - 1 != 0) res.grad_x = slope(px, tail_prev2);
                    expected_q.push_back(res);
                end
                if (c == w - 1) begin
                    res           = '0;
                    res.row       = ROW_BITS'(r);
                    res.col       = COL_BITS'(c);
                    res.frame_end = 1'b1;
                    expected_q.push_back(res);
                end
                tail_prev2 = tail_prev;
                tail_prev  = px;
            end

            if (c + 1 >= w) begin
                col_idx = 0;
                row_idx = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_idx = c + 1;
                row_idx = r;
            end
        endfunction

        task report(string msg);
            if (errors < 100) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result row %0d col %0d", got.row, got.col));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.grad_x !== want.grad_x)
                report($sformatf("grad_x at (%0d,%0d): got %0d want %0d",
                                 want.row, want.col, got.grad_x, want.grad_x));
            if (got.grad_y !== want.grad_y)
                report($sformatf("grad_y at (%0d,%0d): got %0d want %0d",
                                 want.row, want.col, got.grad_y, want.grad_y));
            if (got.row !== want.row)
                report($sformatf("row: got %0d want %0d", got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("col at row %0d: got %0d want %0d", want.row, got.col, want.col));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end at (%0d,%0d): got %0b want %0b",
                                 want.row, want.col, got.frame_end, want.frame_end));
        endtask

        task drop_missing();
            if (expected_q.size() != 0) begin
                report($sformatf("%0d expected results never arrived", expected_q.size()));
                expected_q.delete();
            end
        endtask
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic [PIX_BITS-1:0]         i_pixel     = '0;
    logic                        i_stall     = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        i_cfg_index = CFG_WIDTH;
    logic [CFG_DBITS-1:0]        i_cfg_data  = '0;
    logic                        o_stall;
    logic                        o_valid;
    logic signed [GRAD_BITS-1:0] o_grad_x;
    logic signed [GRAD_BITS-1:0] o_grad_y;
    logic [ROW_BITS-1:0]         o_out_row;
    logic [COL_BITS-1:0]         o_out_col;
    logic                        o_frame_end;
    logic                        o_cfg_ready;

    gradient_scoreboard sb = new();

    // two 3x3 frames of mostly extreme values, the second continuing without a restart
    logic [PIX_BITS-1:0] directed_px [18] = '{
        16'h0000, 16'h0000, 16'hFFFF,
        16'hFFFF, 16'h3039, 16'h0000,
        16'h0000, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'h0000,
        16'h0000, 16'hAAAA, 16'hFFFF,
        16'hFFFF, 16'h0000, 16'h0000
    };

    int cycle_count = 0;
    int stall_mode  = RX_FREE;
    int stall_left  = 0;
    int burst_left  = 0;
    int cur_w       = 640;
    int cur_h       = 480;
    int settings    = 1;

    central_difference_gradient_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) sb.note_pixel(i_pixel);
            if (o_valid && !i_stall)
                sb.check_result({o_grad_x, o_grad_y, o_out_row, o_out_col, o_frame_end});
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(RX_FREE, RX_HEAVY);
            stall_left = $urandom_range(4, 40);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            RX_FREE:   i_stall <= 1'b0;
            RX_RANDOM: i_stall <= 1'($urandom_range(0, 1));
            default:   i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task send_pixel(input logic [PIX_BITS-1:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_pixel <= PIX_BITS'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task write_reg(input logic idx, input logic [CFG_DBITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CFG_DBITS'($urandom);
        @(posedge i_clk);
    endtask

    // wait for every predicted result, then for the pipeline of row 0 pixels
    task settle();
        int waited;
        waited  = 0;
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        sb.drop_missing();
        repeat (8) @(posedge i_clk);
    endtask

    task run_phase(input bit wr_w, input int w_val, input bit wr_h, input int h_val,
                   input int n_pix, input bit directed);
        if (wr_w) begin
            write_reg(CFG_WIDTH, CFG_DBITS'(w_val));
            cur_w = w_val & 2047;
            if (cur_w < 3) cur_w = 3;
            if (cur_w > MAX_WIDTH) cur_w = MAX_WIDTH;
        end
        if (wr_h) begin
            write_reg(CFG_HEIGHT, CFG_DBITS'(h_val));
            cur_h = h_val & 8191;
            if (cur_h < 3) cur_h = 3;
            if (cur_h > MAX_HEIGHT) cur_h = MAX_HEIGHT;
        end
        if (wr_w || wr_h) settings++;
        for (int k = 0; k < n_pix; k++)
            send_pixel(directed ? directed_px[k] : PIX_BITS'($urandom));
        settle();
    endtask

    initial begin
        int sel;
        int w_val;
        int h_val;
        int n_pix;
        int ew;
        int eh;
        int area;
        bit wr_w;
        bit wr_h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(0, 0, 0, 0, 24, 0);
        run_phase(1, 3, 1, 3, 18, 1);
        run_phase(1, 8191, 1, 4, 12, 0);
        run_phase(1, 3, 1, 8191, 30, 0);
        run_phase(1, 0, 1, 0, 18, 0);

        while (sb.pixels < ITEM_TARGET) begin
            sel   = $urandom_range(0, 9);
            w_val = $urandom_range(3, 9);
            h_val = $urandom_range(3, 7);
            if (sel == 0) w_val = $urandom_range(0, 2);
            if (sel == 1) h_val = $urandom_range(0, 2);
            if (sel == 2) w_val = $urandom_range(1025, 2047);
            if (sel == 5) h_val = $urandom_range(4097, 8191);
            wr_w = (sel != 3);
            wr_h = (sel != 4);
            ew   = wr_w ? ((w_val < 3) ? 3 : (w_val > MAX_WIDTH) ? MAX_WIDTH : w_val) : cur_w;
            eh   = wr_h ? ((h_val < 3) ? 3 : (h_val > MAX_HEIGHT) ? MAX_HEIGHT : h_val) : cur_h;
            area = ew * eh;
            if (area > 100) begin
                n_pix = $urandom_range(1, 200);
            end else begin
                n_pix = area * $urandom_range(0, 2) + $urandom_range(0, area - 1);
                if (n_pix == 0) n_pix = area;
            end
            if (n_pix > ITEM_TARGET - sb.pixels) n_pix = ITEM_TARGET - sb.pixels;
            run_phase(wr_w, w_val, wr_h, h_val, n_pix, 0);
        end

        settle();
        $display("Run covered %0d pixels and %0d checked results over %0d frame settings,",
                 sb.pixels, sb.checked, settings);
        $display("using small and clamped frame sizes, with bursty input and stalls.");
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
